// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/ssp_pkg.sv -----
// Types and constants of the sphere screen projection.
package ssp_pkg;
	localparam int FRAC_SHIFT  = 8;
	localparam int COORD_LIMIT = 4095;
	localparam int RADIUS_K    = 1191450;
	localparam int POS_W   = 29;
	localparam int DIV_W   = POS_W + 1;
	localparam int DEN_W   = POS_W - 1 - FRAC_SHIFT;
	localparam int REM_W   = DEN_W + 1;
	localparam int CRD_W   = 32;
	localparam int EDGE_W  = 12;
	localparam int CTR_W   = 13;
	localparam int RAD_W   = 22;
	localparam int COL_W   = 8;
	localparam int ADDR_W  = 5;

	typedef enum logic [2:0] {
		REG_LEFT   = 3'd0,
		REG_TOP    = 3'd1,
		REG_RIGHT  = 3'd2,
		REG_BOTTOM = 3'd3,
		REG_SOLID  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_FILLED  = 2'd0,
		KIND_OUTLINE = 2'd1,
		KIND_SUN     = 2'd2
	} kind_t;

	typedef struct packed {
		logic             neg_x;
		logic             neg_y;
		logic             pos_ok;
		logic             sun;
		logic [COL_W-1:0] colour;
	} side_t;
endpackage

// ----- rtl/ssp_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module ssp_divider (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ssp_pkg::DIV_W-1:0]   dividend,
	input  logic [ssp_pkg::DEN_W-1:0]   divisor,
	output logic [ssp_pkg::DIV_W-1:0]   quotient
);
	localparam int N = ssp_pkg::DIV_W;
	localparam int RW = ssp_pkg::REM_W;

	logic [N-1:0]                num_q [N];
	logic [ssp_pkg::DEN_W-1:0]   den_q [N];
	logic [RW-1:0]               rem_q [N];
	logic [N-1:0]                quo_q [N+1];

	assign num_q[0] = dividend;
	assign den_q[0] = divisor;
	assign rem_q[0] = '0;
	assign quo_q[0] = '0;

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic [RW-1:0] trial;
		logic          fits;
		assign trial = {rem_q[g][RW-2:0], num_q[g][N-1]};
		assign fits  = (trial >= {1'b0, den_q[g]});
		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[g+1] <= {quo_q[g][N-2:0], fits};
			end
		end
		if (g < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					num_q[g+1] <= {num_q[g][N-2:0], 1'b0};
					den_q[g+1] <= den_q[g];
					rem_q[g+1] <= fits ? (trial - {1'b0, den_q[g]}) : trial;
				end
			end
		end
	end

	assign quotient = quo_q[N];
endmodule

// ----- rtl/sphere_screen_projection.sv -----
// Top level: projects a body onto the screen, culls and clamps it.
//
//  channel | signals                                   | moves
//  body    | body_valid/body_ready, pos_*, is_sun, ... | one body word
//  proj    | proj_valid/proj_ready, visible, ...       | one projection word
//  config  | psel/penable/pwrite/paddr/pwdata/prdata   | register access
//
// The pipeline holds an input register, 30 divider stages and two output stages.
// One word per cycle while proj does not stall; the divider pipeline resolves one bit per stage.
// A stall on proj holds the whole pipeline; nothing is dropped or repeated.
// arst_n clears valid bits and loads register defaults.
`include "assert_macros.svh"
module sphere_screen_projection (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ssp_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            body_valid,
	output logic                            body_ready,
	input  logic signed [ssp_pkg::POS_W-1:0] pos_x,
	input  logic signed [ssp_pkg::POS_W-1:0] pos_y,
	input  logic signed [ssp_pkg::POS_W-1:0] pos_z,
	input  logic                            is_sun,
	input  logic [ssp_pkg::COL_W-1:0]       body_colour,
	output logic                            proj_valid,
	input  logic                            proj_ready,
	output logic                            visible,
	output logic signed [ssp_pkg::CTR_W-1:0] centre_x,
	output logic signed [ssp_pkg::CTR_W-1:0] centre_y,
	output logic signed [ssp_pkg::RAD_W-1:0] radius,
	output logic [1:0]                      draw_kind,
	output logic [ssp_pkg::COL_W-1:0]       colour_out
);
	localparam int N  = ssp_pkg::DIV_W;
	localparam int CW = ssp_pkg::CRD_W;

	// configuration
	logic [ssp_pkg::EDGE_W-1:0] left_q, top_q, right_q, bottom_q;
	logic                       solid_q;
	logic                       wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= ssp_pkg::EDGE_W'(240);
			bottom_q <= ssp_pkg::EDGE_W'(160);
			solid_q  <= 1'b1;
		end else if (wr) begin
			case (ssp_pkg::reg_idx_t'(paddr[ssp_pkg::ADDR_W-1:2]))
				ssp_pkg::REG_LEFT:   left_q   <= pwdata[ssp_pkg::EDGE_W-1:0];
				ssp_pkg::REG_TOP:    top_q    <= pwdata[ssp_pkg::EDGE_W-1:0];
				ssp_pkg::REG_RIGHT:  right_q  <= pwdata[ssp_pkg::EDGE_W-1:0];
				ssp_pkg::REG_BOTTOM: bottom_q <= pwdata[ssp_pkg::EDGE_W-1:0];
				ssp_pkg::REG_SOLID:  solid_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ssp_pkg::reg_idx_t'(paddr[ssp_pkg::ADDR_W-1:2]))
			ssp_pkg::REG_LEFT:   prdata = 32'(left_q);
			ssp_pkg::REG_TOP:    prdata = 32'(top_q);
			ssp_pkg::REG_RIGHT:  prdata = 32'(right_q);
			ssp_pkg::REG_BOTTOM: prdata = 32'(bottom_q);
			ssp_pkg::REG_SOLID:  prdata = 32'(solid_q);
			default:             prdata = '0;
		endcase
	end

	// pipeline advance
	logic en;
	assign en         = !proj_valid || proj_ready;
	assign body_ready = en;

	// stage 1: magnitudes, signs, divisor
	logic [N-1:0]     px2, py2;
	logic             d_pos;
	logic             v_s1;
	logic [N-1:0]     magx_s1, magy_s1;
	logic [ssp_pkg::DEN_W-1:0] den_s1;
	ssp_pkg::side_t   side_s1;

	assign px2   = {pos_x, 1'b0};
	assign py2   = {pos_y, 1'b0};
	assign d_pos = !pos_z[ssp_pkg::POS_W-1] && (|pos_z[ssp_pkg::POS_W-2:ssp_pkg::FRAC_SHIFT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= body_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			magx_s1 <= pos_x[ssp_pkg::POS_W-1] ? (~px2 + N'(1)) : px2;
			magy_s1 <= pos_y[ssp_pkg::POS_W-1] ? (~py2 + N'(1)) : py2;
			// d <= 0 uses divisor 1, which gives the undivided position
			den_s1  <= d_pos ? pos_z[ssp_pkg::POS_W-2:ssp_pkg::FRAC_SHIFT]
			                 : ssp_pkg::DEN_W'(1);
			side_s1.neg_x  <= pos_x[ssp_pkg::POS_W-1];
			side_s1.neg_y  <= pos_y[ssp_pkg::POS_W-1];
			side_s1.pos_ok <= !pos_z[ssp_pkg::POS_W-1] && (|pos_z);
			side_s1.sun    <= is_sun;
			side_s1.colour <= body_colour;
		end
	end

	// dividers
	logic [N-1:0] qx, qy, qr;

	ssp_divider u_div_x (.clk(clk), .en(en), .dividend(magx_s1), .divisor(den_s1), .quotient(qx));
	ssp_divider u_div_y (.clk(clk), .en(en), .dividend(magy_s1), .divisor(den_s1), .quotient(qy));
	ssp_divider u_div_r (
		.clk(clk), .en(en), .dividend(N'(ssp_pkg::RADIUS_K)), .divisor(den_s1), .quotient(qr)
	);

	// sideband alongside the divider
	logic           vld_q  [N+1];
	ssp_pkg::side_t side_q [N+1];

	assign vld_q[0]  = v_s1;
	assign side_q[0] = side_s1;

	for (genvar g = 0; g < N; g++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g+1] <= 1'b0;
			end else if (en) begin
				vld_q[g+1] <= vld_q[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_q[g+1] <= side_q[g];
			end
		end
	end

	// stage 2: signed centre and radius
	logic signed [CW-1:0] qxs, qys;
	logic                 v_s2;
	logic signed [CW-1:0] sx_s2, sy_s2, rad_s2;
	ssp_pkg::side_t       side_s2;

	assign qxs = side_q[N].neg_x ? -$signed(CW'(qx)) : $signed(CW'(qx));
	assign qys = side_q[N].neg_y ? $signed(CW'(qy)) : -$signed(CW'(qy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= vld_q[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2   <= (qxs >>> 1) + $signed(CW'(right_q[ssp_pkg::EDGE_W-1:1]));
			sy_s2   <= (qys >>> 1) + $signed(CW'(bottom_q[ssp_pkg::EDGE_W-1:1]));
			rad_s2  <= $signed(CW'(qr[ssp_pkg::RAD_W-1:0]));
			side_s2 <= side_q[N];
		end
	end

	// stage 3: cull, clamp, output register
	logic                    culled;
	logic signed [CW-1:0]    lim;
	logic signed [ssp_pkg::CTR_W-1:0] cx, cy;
	ssp_pkg::kind_t          kind;

	assign lim = CW'(ssp_pkg::COORD_LIMIT);

	always_comb begin
		culled = (sx_s2 + rad_s2 < $signed(CW'(left_q))) ||
		         (sx_s2 - rad_s2 > $signed(CW'(right_q))) ||
		         (sy_s2 + rad_s2 < $signed(CW'(top_q))) ||
		         (sy_s2 - rad_s2 > $signed(CW'(bottom_q))) ||
		         !side_s2.pos_ok;
		if (sx_s2 > lim)        cx = ssp_pkg::CTR_W'(lim);
		else if (sx_s2 < -lim)  cx = ssp_pkg::CTR_W'(-lim);
		else                    cx = sx_s2[ssp_pkg::CTR_W-1:0];
		if (sy_s2 > lim)        cy = ssp_pkg::CTR_W'(lim);
		else if (sy_s2 < -lim)  cy = ssp_pkg::CTR_W'(-lim);
		else                    cy = sy_s2[ssp_pkg::CTR_W-1:0];
		if (side_s2.sun)        kind = ssp_pkg::KIND_SUN;
		else if (solid_q)       kind = ssp_pkg::KIND_FILLED;
		else                    kind = ssp_pkg::KIND_OUTLINE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj_valid <= 1'b0;
		end else if (en) begin
			proj_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			visible    <= !culled;
			centre_x   <= culled ? '0 : cx;
			centre_y   <= culled ? '0 : cy;
			radius     <= culled ? '0 : rad_s2[ssp_pkg::RAD_W-1:0];
			draw_kind  <= culled ? 2'(ssp_pkg::KIND_FILLED) : 2'(kind);
			colour_out <= (culled || kind != ssp_pkg::KIND_FILLED) ? '0 : side_s2.colour;
		end
	end

	`ASSERT_IMPLIES(a_vis_radius, clk, arst_n, proj_valid && visible, radius > 0)
	`ASSERT_IMPLIES(a_colour_kind, clk, arst_n,
		proj_valid && draw_kind != 2'(ssp_pkg::KIND_FILLED), colour_out == '0)
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, v_s2 && proj_valid && !proj_ready, v_s2)
endmodule

// ----- tb/sphere_screen_projection_tb.sv -----
// Self-checking testbench for the sphere screen projection block.
`timescale 1ns / 1ps
module sphere_screen_projection_tb;

	typedef struct {
		logic                             vis;
		logic signed [ssp_pkg::CTR_W-1:0] cx;
		logic signed [ssp_pkg::CTR_W-1:0] cy;
		logic signed [ssp_pkg::RAD_W-1:0] rad;
		logic [1:0]                       kind;
		logic [ssp_pkg::COL_W-1:0]        col;
	} proj_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ssp_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic body_valid = 1'b0;
	logic body_ready;
	logic signed [ssp_pkg::POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic is_sun = 1'b0;
	logic [ssp_pkg::COL_W-1:0] body_colour = '0;
	logic proj_valid;
	logic proj_ready = 1'b0;
	logic visible;
	logic signed [ssp_pkg::CTR_W-1:0] centre_x, centre_y;
	logic signed [ssp_pkg::RAD_W-1:0] radius;
	logic [1:0] draw_kind;
	logic [ssp_pkg::COL_W-1:0] colour_out;

	longint edge_left = 0, edge_top = 0, edge_right = 240, edge_bottom = 160;
	logic solid = 1'b1;

	proj_t expected_q[$];
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit hold_off = 1'b0;
	int mismatches = 0, words_sent = 0, words_checked = 0, culled_seen = 0;
	int idle_cycles = 0;

	sphere_screen_projection i_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint asr(longint v, int n);
		return (v >= 0) ? (v >>> n) : ~((~v) >>> n);
	endfunction

	function automatic longint lim(longint v);
		if (v > ssp_pkg::COORD_LIMIT)
			return ssp_pkg::COORD_LIMIT;
		if (-v > ssp_pkg::COORD_LIMIT)
			return -ssp_pkg::COORD_LIMIT;
		return v;
	endfunction

	function automatic longint sext_pos(longint v);
		return longint'($signed(ssp_pkg::POS_W'(v)));
	endfunction

	function automatic proj_t project_body(longint px, longint py, longint pz, logic sun,
			logic [7:0] col);
		proj_t p;
		longint d, sx, sy, rad;
		d = asr(pz, 8);
		if (d > 0) begin
			sx = asr((px * 2) / d, 1);
			sy = asr(-((py * 2) / d), 1);
		end else begin
			sx = px;
			sy = -py;
		end
		sx += edge_right >> 1;
		sy += edge_bottom >> 1;
		rad = (d > 0) ? (ssp_pkg::RADIUS_K / d) : ssp_pkg::RADIUS_K;
		p = '{1'b0, '0, '0, '0, 2'd0, '0};
		if (sx + rad < edge_left || sx - rad > edge_right || sy + rad < edge_top ||
				sy - rad > edge_bottom || pz <= 0)
			return p;
		p.vis = 1'b1;
		p.cx = ssp_pkg::CTR_W'(lim(sx));
		p.cy = ssp_pkg::CTR_W'(lim(sy));
		p.rad = ssp_pkg::RAD_W'(rad);
		p.kind = sun ? ssp_pkg::KIND_SUN :
			(solid ? ssp_pkg::KIND_FILLED : ssp_pkg::KIND_OUTLINE);
		p.col = (p.kind == ssp_pkg::KIND_FILLED) ? col : '0;
		return p;
	endfunction

	task automatic write_reg(ssp_pkg::reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ssp_pkg::ADDR_W'(4 * idx);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ssp_pkg::REG_LEFT: edge_left = val[11:0];
			ssp_pkg::REG_TOP: edge_top = val[11:0];
			ssp_pkg::REG_RIGHT: edge_right = val[11:0];
			ssp_pkg::REG_BOTTOM: edge_bottom = val[11:0];
			ssp_pkg::REG_SOLID: solid = val[0];
			default: ;
		endcase
	endtask

	task automatic send_body(longint px, longint py, longint pz, logic sun, logic [7:0] col);
		while ($urandom_range(99) < send_idle_pct) begin
			body_valid <= 1'b0;
			@(posedge clk);
		end
		body_valid <= 1'b1;
		pos_x <= ssp_pkg::POS_W'(px);
		pos_y <= ssp_pkg::POS_W'(py);
		pos_z <= ssp_pkg::POS_W'(pz);
		is_sun <= sun;
		body_colour <= col;
		@(posedge clk);
		while (!body_ready) @(posedge clk);
		expected_q.push_back(project_body(sext_pos(px), sext_pos(py), sext_pos(pz), sun, col));
		words_sent++;
	endtask

	task automatic drain();
		body_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n)
			proj_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		proj_t e;
		if (arst_n && proj_valid && proj_ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected projection word");
			end else begin
				e = expected_q.pop_front();
				words_checked++;
				if (!e.vis)
					culled_seen++;
				if (visible !== e.vis || centre_x !== e.cx || centre_y !== e.cy ||
						radius !== e.rad || draw_kind !== e.kind || colour_out !== e.col) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0b %0d %0d %0d %0d %0d got %0b %0d %0d %0d %0d %0d",
							e.vis, e.cx, e.cy, e.rad, e.kind, e.col, visible, centre_x,
							centre_y, radius, draw_kind, colour_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((body_valid && body_ready) || (proj_valid && proj_ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("[sphere_screen_projection] ERROR");
			$finish;
		end
	end

	function automatic longint rand_pos();
		case ($urandom_range(3))
			0: return longint'($signed(ssp_pkg::POS_W'($urandom)));
			1: return $signed({1'b0, 31'($urandom_range(40000))}) - 20000;
			2: return $urandom_range(1) ? 268435455 : -268435456;
			default: return $signed({1'b0, 31'($urandom_range(200000))}) - 100000;
		endcase
	endfunction

	function automatic longint rand_depth();
		case ($urandom_range(4))
			0: return longint'($signed(ssp_pkg::POS_W'($urandom)));
			1: return $urandom_range(511);
			2: return -longint'($urandom_range(1000));
			default: return 256 + $urandom_range(4000000);
		endcase
	endfunction

	task automatic test_directed();
		longint xs[5] = '{0, 268435455, -268435455, 1000, -1000};
		longint zs[5] = '{0, 255, 256, 268435455, -268435456};
		foreach (xs[i])
			send_body(xs[i], -xs[i], zs[i], i[0], 8'hFF);
		send_body(0, 0, 1024, 1'b0, 8'hA5);
		send_body(0, 0, 1024, 1'b1, 8'h5A);
		send_body(-1, 1, 512, 1'b0, 8'h00);
		send_body(5000, -5000, 300000, 1'b0, 8'h81);
		send_body(0, 0, -1, 1'b0, 8'h01);
		send_body(268435455, 268435455, 256, 1'b0, 8'h7E);
		send_body(-268435456, -268435456, 268435455, 1'b1, 8'h3C);
		drain();
	endtask

	task automatic test_random(int n);
		repeat (n)
			send_body(rand_pos(), rand_pos(), rand_depth(), 1'($urandom_range(1)),
				8'($urandom));
	endtask

	task automatic test_config_sweep();
		write_reg(ssp_pkg::REG_LEFT, 32'hFFFF_F000 | $urandom_range(200));
		write_reg(ssp_pkg::REG_TOP, $urandom_range(100));
		write_reg(ssp_pkg::REG_RIGHT, 4095);
		write_reg(ssp_pkg::REG_BOTTOM, 4095);
		write_reg(ssp_pkg::REG_SOLID, 32'h2);
		test_random(300);
		drain();
		write_reg(ssp_pkg::REG_LEFT, 4095);
		write_reg(ssp_pkg::REG_TOP, 4095);
		write_reg(ssp_pkg::REG_RIGHT, 0);
		write_reg(ssp_pkg::REG_BOTTOM, 0);
		write_reg(ssp_pkg::REG_SOLID, 1);
		test_random(150);
		drain();
		write_reg(ssp_pkg::REG_LEFT, $urandom_range(4095));
		write_reg(ssp_pkg::REG_TOP, $urandom_range(4095));
		write_reg(ssp_pkg::REG_RIGHT, $urandom_range(4095));
		write_reg(ssp_pkg::REG_BOTTOM, $urandom_range(4095));
		write_reg(ssp_pkg::REG_SOLID, $urandom_range(1));
		test_random(150);
		drain();
		write_reg(ssp_pkg::REG_LEFT, 0);
		write_reg(ssp_pkg::REG_TOP, 0);
		write_reg(ssp_pkg::REG_RIGHT, 240);
		write_reg(ssp_pkg::REG_BOTTOM, 160);
		write_reg(ssp_pkg::REG_SOLID, 1);
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			test_random(180);
			begin
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 23;
		recv_idle_pct = 64;
		test_directed();
		test_random(300);
		drain();
		send_idle_pct = 64;
		recv_idle_pct = 23;
		test_config_sweep();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(400);
		drain();
		test_backpressure();
		$display("sent %0d body words, checked %0d projections (%0d culled)",
			words_sent, words_checked, culled_seen);
		$display("screen edges swept over extremes, both solid settings, long output stall");
		if (mismatches == 0 && expected_q.size() == 0)
			$display("[sphere_screen_projection] OK");
		else
			$display("[sphere_screen_projection] ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ssp_pkg.sv
rtl/ssp_divider.sv
rtl/sphere_screen_projection.sv
tb/sphere_screen_projection_tb.sv
